/* rtl/cdm_pkg.sv */
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared constants, types and codes of the calendar task due matcher.
// ----------------------------------------------------------------------------
package cdm_pkg;

    localparam int TASK_COUNT  = 8;
    localparam int OFFSET_BITS = 20;
    localparam int REG_COUNT   = 8;
    localparam int ENTRY_W     = OFFSET_BITS + 4;
    localparam int IDX_W       = $clog2(REG_COUNT);
    localparam int ELAPSED_W   = 32;
    localparam int MASK_W      = 8;

    typedef enum logic [2:0] {
        KIND_ONCE    = 3'd0,
        KIND_CYCLE   = 3'd1,
        KIND_HOUR    = 3'd2,
        KIND_TWOHOUR = 3'd3,
        KIND_DAY     = 3'd4,
        KIND_WEEK    = 3'd5,
        KIND_MONTH   = 3'd6,
        KIND_YEAR    = 3'd7
    } t_kind;

    // Broken-down local time of one tick.
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [8:0] yday;
    } t_time;

    // Per-tick control handed to the task unit.
    typedef struct packed {
        logic                 counted;
        logic                 advance;
        logic [ELAPSED_W-1:0] elapsed;
    } t_tick_ctl;

endpackage

/* rtl/cdm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cdm_cfg_regs
// Task entry registers: written by the configuration port, read by index.
// ----------------------------------------------------------------------------
module cdm_cfg_regs import cdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_idx,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]   i_rd_idx,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] r_entry [REG_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_entry[k] <= '0;
            end
        end else if (i_wr_en) begin
            r_entry[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_entry[i_rd_idx];

endmodule

/* rtl/cdm_task_unit.sv */
// ----------------------------------------------------------------------------
// cdm_task_unit
// Shared evaluator: steps one task's phase and decides whether it is due.
// ----------------------------------------------------------------------------
module cdm_task_unit import cdm_pkg::*; (
    input  logic [ENTRY_W-1:0]     i_entry,
    input  logic [OFFSET_BITS-1:0] i_phase,
    input  t_time                  i_time,
    input  t_tick_ctl              i_ctl,
    output logic [OFFSET_BITS-1:0] o_phase,
    output logic                   o_due
);

    logic [OFFSET_BITS-1:0] ofs;
    t_kind                  kind;
    logic                   en;
    logic [OFFSET_BITS:0]   nxt;
    logic [OFFSET_BITS-1:0] phase_used;
    logic                   sec0;
    logic                   top_of_hour;
    logic                   midnight;
    logic                   hr_odd;
    logic [OFFSET_BITS-1:0] min_w;
    logic [OFFSET_BITS-1:0] hour_w;
    logic                   hit;

    assign ofs  = i_entry[OFFSET_BITS-1:0];
    assign kind = t_kind'(i_entry[OFFSET_BITS+2:OFFSET_BITS]);
    assign en   = i_entry[OFFSET_BITS+3];

    // The phase wraps when it reaches or passes the current period field.
    assign nxt = {1'b0, i_phase} + (OFFSET_BITS+1)'(1);
    always_comb begin
        if (ofs == '0 || nxt >= {1'b0, ofs}) begin
            o_phase = '0;
        end else begin
            o_phase = nxt[OFFSET_BITS-1:0];
        end
    end
    assign phase_used = i_ctl.advance ? o_phase : i_phase;

    assign sec0        = (i_time.sec == 6'd0);
    assign top_of_hour = sec0 && (i_time.min == 6'd0);
    assign midnight    = top_of_hour && (i_time.hour == 5'd0);
    assign hr_odd      = i_time.hour[0];
    assign min_w       = OFFSET_BITS'(i_time.min);
    assign hour_w      = OFFSET_BITS'(i_time.hour);

    always_comb begin
        unique case (kind)
            KIND_ONCE: begin
                hit = i_ctl.counted && (i_ctl.elapsed == ELAPSED_W'(ofs));
            end
            KIND_CYCLE: begin
                hit = i_ctl.counted && (ofs != '0) && (i_ctl.elapsed != '0)
                      && (phase_used == '0);
            end
            KIND_HOUR: begin
                if (ofs >= OFFSET_BITS'(59)) begin
                    hit = top_of_hour;
                end else begin
                    hit = sec0 && (min_w == ofs);
                end
            end
            KIND_TWOHOUR: begin
                if (ofs >= OFFSET_BITS'(119)) begin
                    hit = top_of_hour && !hr_odd;
                end else if (ofs >= OFFSET_BITS'(60)) begin
                    hit = sec0 && hr_odd && (min_w == ofs - OFFSET_BITS'(60));
                end else begin
                    hit = sec0 && !hr_odd && (min_w == ofs);
                end
            end
            KIND_DAY: begin
                if (ofs >= OFFSET_BITS'(23)) begin
                    hit = midnight;
                end else begin
                    hit = top_of_hour && (hour_w == ofs);
                end
            end
            KIND_WEEK: begin
                if (ofs >= OFFSET_BITS'(6)) begin
                    hit = midnight && (i_time.wday == 3'd0);
                end else begin
                    hit = midnight && (OFFSET_BITS'(i_time.wday) == ofs);
                end
            end
            KIND_MONTH: begin
                // Offsets of 28 and above never match any day.
                if (ofs >= OFFSET_BITS'(28)) begin
                    hit = 1'b0;
                end else begin
                    hit = midnight && (OFFSET_BITS'(i_time.mday) == ofs);
                end
            end
            KIND_YEAR: begin
                if (ofs >= OFFSET_BITS'(365)) begin
                    hit = midnight && (i_time.yday == 9'd0);
                end else begin
                    hit = midnight && (OFFSET_BITS'(i_time.yday) == ofs);
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    assign o_due = en && hit;

endmodule

/* rtl/calendar_task_due_matcher_top.sv */
// ----------------------------------------------------------------------------
// calendar_task_due_matcher_top
// Per-second task scheduler: returns the mask of due tasks for each tick.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+--------------------------------------
//  tick in  | i_valid      | o_ready      | i_second_of_minute .. i_day_of_year
//  result   | o_valid      | i_ready      | o_due_mask, o_seconds_since_start
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each tick item is handled in order: accept it and update the elapsed
// counter, pass each task entry in turn through the shared task unit, and
// load the result register. The input is not ready while a tick is in work,
// and the last step waits while a previous result is still held downstream.
// Synchronous reset clears the counters, phases and task entries at once.
module calendar_task_due_matcher_top import cdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [5:0]           i_second_of_minute,
    input  logic [5:0]           i_minute_of_hour,
    input  logic [4:0]           i_hour_of_day,
    input  logic [2:0]           i_day_of_week,
    input  logic [4:0]           i_day_of_month,
    input  logic [8:0]           i_day_of_year,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MASK_W-1:0]    o_due_mask,
    output logic [ELAPSED_W-1:0] o_seconds_since_start,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [ENTRY_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam logic [IDX_W:0] TaskLimit = (IDX_W+1)'(TASK_COUNT);
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(REG_COUNT - 1);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_started;
    logic [ELAPSED_W-1:0]   r_elapsed;
    logic                   r_counted;
    logic                   r_advance;
    t_time                  r_time;
    logic [MASK_W-1:0]      r_mask;
    logic [OFFSET_BITS-1:0] r_phase [REG_COUNT];
    logic                   r_out_valid;
    logic [MASK_W-1:0]      r_out_mask;
    logic [ELAPSED_W-1:0]   r_out_secs;

    logic                   in_acc;
    logic                   out_load;
    logic [ENTRY_W-1:0]     entry;
    logic [OFFSET_BITS-1:0] phase_nxt;
    logic                   due;
    t_tick_ctl              ctl;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);

    cdm_cfg_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid && o_cfg_ready),
        .i_wr_idx  (i_cfg_index),
        .i_wr_data (i_cfg_data),
        .i_rd_idx  (r_idx),
        .o_rd_data (entry)
    );

    assign ctl.counted = r_counted;
    assign ctl.advance = r_advance;
    assign ctl.elapsed = r_elapsed;

    cdm_task_unit u_unit (
        .i_entry (entry),
        .i_phase (r_phase[r_idx]),
        .i_time  (r_time),
        .i_ctl   (ctl),
        .o_phase (phase_nxt),
        .o_due   (due)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_idx == LastIdx) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_elapsed   <= '0;
            r_counted   <= 1'b0;
            r_advance   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_idx <= '0;
                // Phases are still zero before the first tick, so no clear is needed.
                if (!r_started) begin
                    r_started <= 1'b1;
                    r_counted <= 1'b1;
                    r_advance <= 1'b0;
                end else if (r_elapsed != '1) begin
                    r_elapsed <= r_elapsed + ELAPSED_W'(1);
                    r_counted <= 1'b1;
                    r_advance <= 1'b1;
                end else begin
                    r_counted <= 1'b0;
                    r_advance <= 1'b0;
                end
            end
            if (r_state == S_RUN) begin
                r_idx <= r_idx + IDX_W'(1);
                if (r_advance) begin
                    r_phase[r_idx] <= phase_nxt;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time.sec  <= i_second_of_minute;
            r_time.min  <= i_minute_of_hour;
            r_time.hour <= i_hour_of_day;
            r_time.wday <= i_day_of_week;
            r_time.mday <= i_day_of_month;
            r_time.yday <= i_day_of_year;
            r_mask      <= '0;
        end
        if (r_state == S_RUN) begin
            r_mask[r_idx] <= due && ({1'b0, r_idx} < TaskLimit);
        end
        if (out_load) begin
            r_out_mask <= r_mask;
            r_out_secs <= r_elapsed;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_due_mask            = r_out_mask;
    assign o_seconds_since_start = r_out_secs;

endmodule

/* dv/cdm_due_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdm_due_checker
// Watches the tick, result and task-table channels of the due matcher. It
// keeps its own copy of the task table, the elapsed counter and the phase
// counters, predicts the due mask of every accepted tick, and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cdm_due_checker import cdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic [5:0]           i_second_of_minute,
    input  logic [5:0]           i_minute_of_hour,
    input  logic [4:0]           i_hour_of_day,
    input  logic [2:0]           i_day_of_week,
    input  logic [4:0]           i_day_of_month,
    input  logic [8:0]           i_day_of_year,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic [MASK_W-1:0]    o_due_mask,
    input  logic [ELAPSED_W-1:0] o_seconds_since_start,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [ENTRY_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_due_hits
);

    typedef struct packed {
        logic [MASK_W-1:0]    mask;
        logic [ELAPSED_W-1:0] elapsed;
    } t_due_result;

    t_due_result            due_expected_q[$];
    logic [ENTRY_W-1:0]     task_table [REG_COUNT];
    logic [OFFSET_BITS-1:0] task_phase [REG_COUNT];
    logic                   tick_started;
    logic [ELAPSED_W-1:0]   elapsed_secs;
    int                     fail_count = 0;
    int                     checked    = 0;
    int                     due_hits   = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_due_hits   = 0;
    end

    // Decides whether one task entry is due for the given tick.
    function automatic logic task_is_due(logic [ENTRY_W-1:0] ent,
                                         logic [OFFSET_BITS-1:0] phase,
                                         t_time tm, logic counted,
                                         logic [ELAPSED_W-1:0] el);
        logic [OFFSET_BITS-1:0] ofs;
        t_kind                  kind;
        logic                   sec0;
        logic                   midnight;
        logic                   hit;
        ofs      = ent[OFFSET_BITS-1:0];
        kind     = t_kind'(ent[OFFSET_BITS+2:OFFSET_BITS]);
        sec0     = (tm.sec == 0);
        midnight = sec0 && (tm.min == 0) && (tm.hour == 0);
        hit      = 1'b0;
        if (ent[OFFSET_BITS+3]) begin
            case (kind)
                KIND_ONCE: begin
                    hit = counted && (el == ELAPSED_W'(ofs));
                end
                KIND_CYCLE: begin
                    hit = counted && (ofs != 0) && (el != 0) && (phase == 0);
                end
                KIND_HOUR: begin
                    hit = sec0 && ((ofs >= 59) ? (tm.min == 0) : (tm.min == ofs));
                end
                KIND_TWOHOUR: begin
                    if (ofs >= 119)
                        hit = sec0 && (tm.min == 0) && !tm.hour[0];
                    else if (ofs >= 60)
                        hit = sec0 && tm.hour[0] && (tm.min == ofs - 60);
                    else
                        hit = sec0 && !tm.hour[0] && (tm.min == ofs);
                end
                KIND_DAY: begin
                    hit = sec0 && (tm.min == 0) &&
                          ((ofs >= 23) ? (tm.hour == 0) : (tm.hour == ofs));
                end
                KIND_WEEK: begin
                    hit = midnight && ((ofs >= 6) ? (tm.wday == 0) : (tm.wday == ofs));
                end
                KIND_MONTH: begin
                    // Offsets of 28 and above never match any day.
                    hit = (ofs < 28) && midnight && (tm.mday == ofs);
                end
                default: begin
                    hit = midnight && ((ofs >= 365) ? (tm.yday == 0) : (tm.yday == ofs));
                end
            endcase
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin : watch
        t_time                tm;
        logic                 counted;
        logic [OFFSET_BITS:0] nxt;
        logic [OFFSET_BITS-1:0] per;
        t_due_result          want;
        if (!i_rst_n) begin
            tick_started = 1'b0;
            elapsed_secs = '0;
            for (int k = 0; k < REG_COUNT; k++) begin
                task_table[k] = '0;
                task_phase[k] = '0;
            end
            due_expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                task_table[i_cfg_index] = i_cfg_data;

            if (i_valid && o_ready) begin
                tm.sec  = i_second_of_minute;
                tm.min  = i_minute_of_hour;
                tm.hour = i_hour_of_day;
                tm.wday = i_day_of_week;
                tm.mday = i_day_of_month;
                tm.yday = i_day_of_year;
                counted = 1'b0;
                if (!tick_started) begin
                    tick_started = 1'b1;
                    elapsed_secs = '0;
                    for (int k = 0; k < REG_COUNT; k++)
                        task_phase[k] = '0;
                    counted = 1'b1;
                end else if (elapsed_secs != '1) begin
                    elapsed_secs = elapsed_secs + 1'b1;
                    counted      = 1'b1;
                    // Phases follow the offset field of every entry, whatever its kind.
                    for (int k = 0; k < REG_COUNT; k++) begin
                        per = task_table[k][OFFSET_BITS-1:0];
                        nxt = {1'b0, task_phase[k]} + 1'b1;
                        task_phase[k] = (per == 0 || nxt >= per) ? '0 : nxt[OFFSET_BITS-1:0];
                    end
                end
                want.mask    = '0;
                want.elapsed = elapsed_secs;
                for (int k = 0; k < TASK_COUNT; k++)
                    want.mask[k] = task_is_due(task_table[k], task_phase[k], tm,
                                               counted, elapsed_secs);
                due_expected_q.push_back(want);
            end

            if (o_valid && i_ready) begin
                if (due_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR %0t: result with no tick waiting: mask %02h elapsed %0d",
                                 $realtime, o_due_mask, o_seconds_since_start);
                end else begin
                    want = due_expected_q.pop_front();
                    if (o_due_mask !== want.mask ||
                        o_seconds_since_start !== want.elapsed) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR %0t: mask exp %02h got %02h, elapsed exp %0d got %0d",
                                     $realtime, want.mask, o_due_mask,
                                     want.elapsed, o_seconds_since_start);
                    end
                end
                checked++;
                if (o_due_mask != 0)
                    due_hits++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_expected_q.size();
        o_checked    <= checked;
        o_due_hits   <= due_hits;
    end

endmodule

/* dv/calendar_task_due_matcher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_task_due_matcher_top_tb
// Drives ticks of broken-down local time and task-table writes into the due
// matcher with random pauses on the tick and result channels, and lets the
// checker beside the block predict and compare every due mask and elapsed count.
// ----------------------------------------------------------------------------
module calendar_task_due_matcher_top_tb;
    import cdm_pkg::*;

    localparam int PHASE_TICKS = 240;
    localparam int PHASES      = 7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [5:0]           i_second_of_minute;
    logic [5:0]           i_minute_of_hour;
    logic [4:0]           i_hour_of_day;
    logic [2:0]           i_day_of_week;
    logic [4:0]           i_day_of_month;
    logic [8:0]           i_day_of_year;
    logic                 o_valid;
    logic                 i_ready;
    logic [MASK_W-1:0]    o_due_mask;
    logic [ELAPSED_W-1:0] o_seconds_since_start;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index;
    logic [ENTRY_W-1:0]   i_cfg_data;

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;
    int due_hit_cnt;

    logic [ENTRY_W-1:0] cur_entry [REG_COUNT];
    t_time              dir_times [12];
    int                 n_sent     = 0;
    int                 n_settings = 0;
    bit                 calm       = 1'b0;

    calendar_task_due_matcher_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_second_of_minute    (i_second_of_minute),
        .i_minute_of_hour      (i_minute_of_hour),
        .i_hour_of_day         (i_hour_of_day),
        .i_day_of_week         (i_day_of_week),
        .i_day_of_month        (i_day_of_month),
        .i_day_of_year         (i_day_of_year),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_due_mask            (o_due_mask),
        .o_seconds_since_start (o_seconds_since_start),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    cdm_due_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_second_of_minute    (i_second_of_minute),
        .i_minute_of_hour      (i_minute_of_hour),
        .i_hour_of_day         (i_hour_of_day),
        .i_day_of_week         (i_day_of_week),
        .i_day_of_month        (i_day_of_month),
        .i_day_of_year         (i_day_of_year),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_due_mask            (o_due_mask),
        .o_seconds_since_start (o_seconds_since_start),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_fail_count          (fail_cnt),
        .o_pending             (pending_cnt),
        .o_checked             (checked_cnt),
        .o_due_hits            (due_hit_cnt)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    function automatic logic [ENTRY_W-1:0] pack_entry(logic en, t_kind kind,
                                                      logic [OFFSET_BITS-1:0] ofs);
        return {en, kind, ofs};
    endfunction

    function automatic t_time mk_time(int sec, int min, int hour, int wday,
                                      int mday, int yday);
        t_time t;
        t.sec  = 6'(sec);
        t.min  = 6'(min);
        t.hour = 5'(hour);
        t.wday = 3'(wday);
        t.mday = 5'(mday);
        t.yday = 9'(yday);
        return t;
    endfunction

    function automatic logic [ENTRY_W-1:0] rand_task_entry();
        logic                   en;
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] ofs;
        int                     r;
        en   = ($urandom_range(0, 9) != 0);
        kind = t_kind'($urandom_range(0, 7));
        r    = $urandom_range(0, 99);
        case (kind)
            KIND_ONCE:    ofs = OFFSET_BITS'(n_sent + $urandom_range(0, 260));
            KIND_CYCLE: begin
                if (r < 10)
                    ofs = '0;
                else if (r < 20)
                    ofs = OFFSET_BITS'(1);
                else if (r < 28)
                    ofs = '1;
                else
                    ofs = OFFSET_BITS'($urandom_range(2, 25));
            end
            KIND_HOUR:    ofs = OFFSET_BITS'($urandom_range(0, 63));
            KIND_TWOHOUR: ofs = OFFSET_BITS'($urandom_range(0, 127));
            KIND_DAY:     ofs = OFFSET_BITS'($urandom_range(0, 31));
            KIND_WEEK:    ofs = OFFSET_BITS'($urandom_range(0, 7));
            KIND_MONTH:   ofs = OFFSET_BITS'($urandom_range(0, 31));
            default:      ofs = OFFSET_BITS'($urandom_range(0, 380));
        endcase
        // Huge calendar offsets exercise the clamping.
        if (kind != KIND_ONCE && kind != KIND_CYCLE && r >= 85)
            ofs = OFFSET_BITS'($urandom);
        return pack_entry(en, kind, ofs);
    endfunction

    // Fields lean toward zero and toward the offsets in the table so that
    // calendar tasks actually come due.
    function automatic t_time rand_tick_time();
        t_time                  t;
        logic [OFFSET_BITS-1:0] hint;
        logic [OFFSET_BITS-1:0] hint_odd;
        int                     r;
        hint     = cur_entry[$urandom_range(0, REG_COUNT - 1)][OFFSET_BITS-1:0];
        hint_odd = hint - 20'd60;
        r = $urandom_range(0, 99);
        t.sec = (r < 55) ? 6'd0 : 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 30)
            t.min = '0;
        else if (r < 55)
            t.min = hint[5:0];
        else if (r < 70)
            t.min = hint_odd[5:0];
        else
            t.min = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 35)
            t.hour = '0;
        else if (r < 60)
            t.hour = hint[4:0];
        else
            t.hour = 5'($urandom_range(0, 31));
        t.wday = ($urandom_range(0, 99) < 40) ? hint[2:0] : 3'($urandom_range(0, 7));
        t.mday = ($urandom_range(0, 99) < 40) ? hint[4:0] : 5'($urandom_range(0, 31));
        t.yday = ($urandom_range(0, 99) < 40) ? hint[8:0] : 9'($urandom_range(0, 511));
        return t;
    endfunction

    // Leaves valid high after acceptance so that a following item goes out
    // without a gap.
    task automatic send_tick(t_time t);
        i_second_of_minute <= t.sec;
        i_minute_of_hour   <= t.min;
        i_hour_of_day      <= t.hour;
        i_day_of_week      <= t.wday;
        i_day_of_month     <= t.mday;
        i_day_of_year      <= t.yday;
        i_valid            <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    task automatic sender_pause();
        int n;
        n = calm ? 0 : pick_pause_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every tick has come back, then lets the clock
    // run on so the block is surely idle.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic load_task_table();
        for (int k = 0; k < REG_COUNT; k++) begin
            i_cfg_index <= IDX_W'(k);
            i_cfg_data  <= cur_entry[k];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_directed();
        for (int i = 0; i < 12; i++) begin
            send_tick(dir_times[i]);
            sender_pause();
        end
    endtask

    // Result side: runs of ready with stalls between them.
    initial begin
        int n;
        forever begin
            n = calm ? 0 : pick_pause_len();
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        #12_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_second_of_minute <= '0;
        i_minute_of_hour   <= '0;
        i_hour_of_day      <= '0;
        i_day_of_week      <= '0;
        i_day_of_month     <= '0;
        i_day_of_year      <= '0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;

        dir_times[0]  = mk_time(0, 0, 0, 0, 1, 0);
        dir_times[1]  = mk_time(63, 63, 31, 7, 31, 511);
        dir_times[2]  = mk_time(60, 0, 0, 0, 1, 0);
        dir_times[3]  = mk_time(0, 59, 2, 1, 2, 1);
        dir_times[4]  = mk_time(0, 0, 1, 2, 3, 4);
        dir_times[5]  = mk_time(0, 0, 0, 6, 27, 364);
        dir_times[6]  = mk_time(0, 0, 0, 3, 28, 365);
        dir_times[7]  = mk_time(0, 30, 5, 4, 5, 5);
        dir_times[8]  = mk_time(0, 58, 13, 5, 6, 6);
        dir_times[9]  = mk_time(0, 0, 23, 6, 31, 200);
        dir_times[10] = mk_time(0, 0, 0, 0, 0, 0);
        dir_times[11] = mk_time(0, 0, 5, 3, 15, 364);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First setting: the once task fires on the very first tick, and the clamped
        // hour, two-hour, day, week and month offsets are present.
        cur_entry[0] = pack_entry(1'b1, KIND_ONCE, 20'd0);
        cur_entry[1] = pack_entry(1'b1, KIND_CYCLE, 20'd1);
        cur_entry[2] = pack_entry(1'b1, KIND_CYCLE, 20'd0);
        cur_entry[3] = pack_entry(1'b1, KIND_HOUR, 20'd59);
        cur_entry[4] = pack_entry(1'b1, KIND_TWOHOUR, 20'd119);
        cur_entry[5] = pack_entry(1'b1, KIND_DAY, 20'd23);
        cur_entry[6] = pack_entry(1'b1, KIND_WEEK, 20'd6);
        cur_entry[7] = pack_entry(1'b1, KIND_MONTH, 20'd28);
        load_task_table();
        send_directed();
        wait_for_results();

        cur_entry[0] = pack_entry(1'b1, KIND_YEAR, 20'd365);
        cur_entry[1] = pack_entry(1'b1, KIND_MONTH, 20'd0);
        cur_entry[2] = pack_entry(1'b1, KIND_TWOHOUR, 20'd60);
        cur_entry[3] = pack_entry(1'b1, KIND_TWOHOUR, 20'd118);
        cur_entry[4] = pack_entry(1'b1, KIND_ONCE, 20'(n_sent + 3));
        cur_entry[5] = pack_entry(1'b1, KIND_WEEK, 20'd3);
        cur_entry[6] = pack_entry(1'b1, KIND_YEAR, 20'd364);
        cur_entry[7] = pack_entry(1'b1, KIND_MONTH, 20'd27);
        load_task_table();
        send_directed();
        wait_for_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                if (ph == 0)
                    cur_entry[k] = '1;
                else if (ph == 1)
                    cur_entry[k] = pack_entry(1'b1, t_kind'(k), 20'd0);
                else
                    cur_entry[k] = rand_task_entry();
            end
            calm = (ph == 2);
            load_task_table();
            for (int i = 0; i < PHASE_TICKS; i++) begin
                send_tick(rand_tick_time());
                sender_pause();
            end
            wait_for_results();
        end
        calm = 1'b0;

        $display("Sent %0d ticks under %0d task tables; %0d results checked.",
                 n_sent, n_settings, checked_cnt);
        $display("%0d results had at least one task due.", due_hit_cnt);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
